FILE: hw/rtl/nth_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the NTC thermostat.
// Also holds the build-time beta-equation functions that fill the conversion ROM.
package nth_pkg;

    localparam int TEMP_W = 17;
    localparam int ADC_IN_W = 10;
    localparam int MAX_SAMPLE_W = 10;

    localparam int BETA_K = 4036;
    localparam int T0_CK = 29815;
    localparam int KELVIN_CK = 27315;
    localparam int LN2_Q30 = 744261118;
    localparam int LOG_FRAC = 24;
    localparam int TEMP_MAX = 34000;
    localparam int TEMP_MIN = -27315;

    // Item kinds carried on the input tuser line.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register indexes on the configuration channel.
    localparam logic [1:0] REG_ON_THR = 2'd0;
    localparam logic [1:0] REG_OFF_THR = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;
    localparam logic [1:0] REG_LOWER = 2'd3;

    typedef enum logic [1:0] {
        MODE_TEMP = 2'd0,
        MODE_ERROR = 2'd1,
        MODE_DASHES = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] on_thr;
        logic signed [TEMP_W-1:0] off_thr;
        logic signed [TEMP_W-1:0] upper;
        logic signed [TEMP_W-1:0] lower;
    } cfg_t;

    typedef struct packed {
        logic relay;
        logic dot;
        logic signed [TEMP_W-1:0] temp;
        mode_t mode;
    } res_t;

    // log2 of n in Q24, truncated, by repeated squaring.
    function automatic logic [63:0] log2_q24(input logic [31:0] n);
        int k;
        logic [63:0] y;
        logic [63:0] res;
        k = 0;
        for (int i = 0; i < 31; i++)
        begin
            if ((n >> (i + 1)) != 32'd0)
            begin
                k = i + 1;
            end
        end
        y = ({32'd0, n} << 30) >> k;
        res = 64'(k) << LOG_FRAC;
        for (int b = LOG_FRAC - 1; b >= 0; b--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                res[b] = 1'b1;
            end
        end
        return res;
    endfunction

    // Signed quotient truncated toward zero, by shift and subtract on the magnitudes.
    function automatic longint quot_trunc(input longint n, input longint d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] rem;
        logic [63:0] quo;
        un = (n < 0) ? 64'(-n) : 64'(n);
        ud = (d < 0) ? 64'(-d) : 64'(d);
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], un[i]};
            if (rem >= ud)
            begin
                rem = rem - ud;
                quo[i] = 1'b1;
            end
        end
        return ((n < 0) != (d < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    // Centidegrees for an average reading a, evaluated at elaboration only.
    function automatic logic signed [TEMP_W-1:0] rom_entry(input int unsigned a,
                                                          input int unsigned adc_bits);
        longint full_sc;
        longint lv;
        longint mag;
        longint lnv;
        longint den;
        longint num;
        longint q;
        logic [63:0] prod;
        full_sc = (longint'(1) << adc_bits) - 1;
        if (a == 0 || longint'(a) >= full_sc)
        begin
            return TEMP_W'(TEMP_MIN);
        end
        lv = longint'(log2_q24(a)) - longint'(log2_q24(32'(full_sc - longint'(a))));
        mag = (lv < 0) ? -lv : lv;
        prod = (64'(mag) * 64'(LN2_Q30)) >> 30;
        mag = longint'(prod);
        lnv = (lv < 0) ? -mag : mag;
        den = longint'(100) * longint'(BETA_K) * (longint'(1) << LOG_FRAC)
            + longint'(T0_CK) * lnv;
        if (den <= 0)
        begin
            return TEMP_W'(TEMP_MAX);
        end
        num = longint'(T0_CK) * longint'(BETA_K) * longint'(100) * (longint'(1) << LOG_FRAC);
        q = quot_trunc(num - longint'(KELVIN_CK) * den, den);
        if (q > TEMP_MAX)
        begin
            q = TEMP_MAX;
        end
        if (q < TEMP_MIN)
        begin
            q = TEMP_MIN;
        end
        return TEMP_W'(q);
    endfunction

endpackage

FILE: hw/rtl/nth_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nth_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/nth_conv_rom.sv
`timescale 1ns / 1ps
// Reading-to-centidegree conversion ROM with a registered read port.
// Contents come from nth_pkg::rom_entry at elaboration.
module nth_conv_rom #(
    parameter int ADC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [ADC_BITS-1:0]               addr,
    output logic signed [nth_pkg::TEMP_W-1:0] rdata
);
    import nth_pkg::*;

    localparam int ROM_SIZE = 1 << ADC_BITS;

    logic signed [TEMP_W-1:0] rom_tab [ROM_SIZE];

    for (genvar i = 0; i < ROM_SIZE; i++)
    begin : g_entry
        localparam logic signed [TEMP_W-1:0] ENTRY = rom_entry(i, ADC_BITS);
        assign rom_tab[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= rom_tab[addr];
        end
    end

endmodule

FILE: hw/rtl/nth_disp.sv
`timescale 1ns / 1ps
// Display and relay decision for a refresh tick, with the relay and blink state.
// Depends on nth_pkg.
module nth_disp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd,
    input  logic                              warm,
    input  logic signed [nth_pkg::TEMP_W-1:0] cur_temp,
    input  nth_pkg::cfg_t                     cfg,
    output nth_pkg::res_t                     res
);
    import nth_pkg::*;

    logic relay_reg;
    logic relay_next;
    logic blink_reg;
    logic blink_next;
    logic fault;
    logic relay_hyst;

    assign fault = (cur_temp > cfg.upper) || (cur_temp < cfg.lower);

    always_comb
    begin
        // The off test comes second, so it wins when the thresholds overlap.
        relay_hyst = relay_reg;
        if (cur_temp > cfg.on_thr)
        begin
            relay_hyst = 1'b1;
        end
        if (cur_temp < cfg.off_thr)
        begin
            relay_hyst = 1'b0;
        end

        blink_next = blink_reg;
        res.mode = MODE_TEMP;
        res.temp = '0;
        res.dot = 1'b0;
        res.relay = 1'b0;
        relay_next = 1'b0;
        if (warm && fault)
        begin
            res.mode = MODE_ERROR;
        end
        else if (!warm)
        begin
            res.mode = MODE_DASHES;
        end
        else
        begin
            res.temp = cur_temp;
            relay_next = relay_hyst;
            res.relay = relay_hyst;
            if (relay_hyst)
            begin
                res.dot = blink_reg;
                blink_next = !blink_reg;
            end
            else
            begin
                res.dot = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg <= 1'b0;
            blink_reg <= 1'b0;
        end
        else if (upd)
        begin
            relay_reg <= relay_next;
            blink_reg <= blink_next;
        end
    end

endmodule

FILE: hw/rtl/ntc_thermostat_hysteresis.sv
`timescale 1ns / 1ps
// Thermostat fed by an NTC thermistor: moving average, beta-equation ROM, hysteresis.
// Depends on nth_pkg, nth_ram, nth_conv_rom and nth_disp.
//
// Input words arrive on the s_ stream. tuser says what the word is: a converter
// sample (op 0) or a display refresh tick (op 1); tdata carries the reading.
// A sample enters a ring of RING_DEPTH readings kept in a RAM, updates the
// running sum, and the truncated average addresses the conversion ROM to give
// the current temperature. Samples give no output word. A tick gives one word
// on the m_ stream, with the display mode in tuser: dashes until the ring has
// filled once, the error pattern when the temperature is outside the limits,
// otherwise the temperature with the relay under on/off hysteresis and the dot
// blinking while the relay is on.
// Every word passes through a five-step pipeline (ring read, sum update,
// reciprocal divide, ROM read, decision); a tick's result then goes to the output
// register, and one word is taken every cycle while the skid register is empty.
// The thresholds and limits are written on the cfg_ channel; the user must write them only while idle, unenforced.
// Reset clears the ring's fill state, the sum, the temperature, the relay and
// blink state and loads the default thresholds. A stalled receiver fills the
// output register and then a skid register; the input then stops accepting.
module ntc_thermostat_hysteresis #(
    parameter int RING_DEPTH = 10,
    parameter int ADC_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_value, [15:10] zero
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] temperature, [17] dot_on, [18] relay_on,
                                   // [23:19] zero
    output logic [1:0]  m_tuser,   // [1:0] display_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import nth_pkg::*;

    localparam int SAMPLE_W = (ADC_BITS < MAX_SAMPLE_W) ? ADC_BITS : MAX_SAMPLE_W;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int SUM_W = $clog2(RING_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
    localparam int DIV_S = SUM_W + $clog2(RING_DEPTH);
    localparam int MUL_W = SUM_W + 2;
    localparam logic [MUL_W-1:0] DIV_M =
        MUL_W'(((longint'(1) << DIV_S) + RING_DEPTH - 1) / RING_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

    // Control and configuration state.
    cfg_t              cfg_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              warmed_reg;
    logic              warmed_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic signed [TEMP_W-1:0] temp_reg;

    // Pipeline.
    logic en;
    logic s_accept;
    logic [SAMPLE_W-1:0] s_sample;
    logic                p1_valid_reg;
    logic                p1_tick_reg;
    logic                p1_warm_reg;
    logic [SLOT_W-1:0]   p1_slot_reg;
    logic [SAMPLE_W-1:0] p1_sample_reg;
    logic                p2_valid_reg;
    logic                p2_tick_reg;
    logic                p2_warm_reg;
    logic                p3_valid_reg;
    logic                p3_tick_reg;
    logic                p3_warm_reg;
    logic [SAMPLE_W-1:0] p3_avg_reg;
    logic                p4_valid_reg;
    logic                p4_tick_reg;
    logic                p4_warm_reg;

    logic                ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W+MUL_W-1:0] prod;
    logic signed [TEMP_W-1:0] rom_q;

    // Output side.
    res_t res;
    logic res_push;
    logic upd_sample;
    logic out_valid_reg;
    res_t out_data_reg;
    logic skid_valid_reg;
    res_t skid_data_reg;

    assign en = !skid_valid_reg;
    assign s_tready = en;
    assign s_accept = s_tvalid && s_tready;
    assign s_sample = s_tdata[SAMPLE_W-1:0];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_thr <= TEMP_W'(600);
            cfg_reg.off_thr <= TEMP_W'(400);
            cfg_reg.upper <= TEMP_W'(5000);
            cfg_reg.lower <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ON_THR:  cfg_reg.on_thr <= cfg_data;
                REG_OFF_THR: cfg_reg.off_thr <= cfg_data;
                REG_UPPER:   cfg_reg.upper <= cfg_data;
                REG_LOWER:   cfg_reg.lower <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stage 0: slot bookkeeping and ring read.
    always_comb
    begin
        slot_next = slot_reg;
        warmed_next = warmed_reg;
        if (s_accept && s_tuser == OP_SAMPLE)
        begin
            if (slot_reg == LAST_SLOT)
            begin
                slot_next = '0;
                warmed_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    nth_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p1_slot_reg),
        .wdata (p1_sample_reg),
        .re    (s_accept),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Stage 1: the ring entry is unwritten until the first wrap, so it counts as zero.
    assign ram_we = en && p1_valid_reg && !p1_tick_reg;
    assign old_sample = p1_warm_reg ? ram_rdata : '0;
    assign sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(p1_sample_reg);

    // Stage 2: divide by the ring depth through an exact reciprocal.
    assign prod = SUM_W'(sum_reg) * DIV_M;

    // Stage 3: conversion ROM read.
    nth_conv_rom #(
        .ADC_BITS (ADC_BITS)
    ) u_rom (
        .clk   (clk),
        .en    (en),
        .addr  (ADC_BITS'(p3_avg_reg)),
        .rdata (rom_q)
    );

    // Stage 4: decision.
    assign upd_sample = en && p4_valid_reg && !p4_tick_reg;
    assign res_push = en && p4_valid_reg && p4_tick_reg;

    nth_disp u_disp (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (res_push),
        .warm     (p4_warm_reg),
        .cur_temp (temp_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            warmed_reg <= 1'b0;
            sum_reg <= '0;
            temp_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            slot_reg <= slot_next;
            warmed_reg <= warmed_next;
            if (p1_valid_reg && !p1_tick_reg)
            begin
                sum_reg <= sum_next;
            end
            if (upd_sample)
            begin
                temp_reg <= rom_q;
            end
            p1_valid_reg <= s_accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_tick_reg <= (s_tuser == OP_TICK);
            p1_warm_reg <= warmed_reg;
            p1_slot_reg <= slot_reg;
            p1_sample_reg <= s_sample;
            p2_tick_reg <= p1_tick_reg;
            p2_warm_reg <= p1_warm_reg;
            p3_tick_reg <= p2_tick_reg;
            p3_warm_reg <= p2_warm_reg;
            p3_avg_reg <= SAMPLE_W'(prod >> DIV_S);
            p4_tick_reg <= p3_tick_reg;
            p4_warm_reg <= p3_warm_reg;
        end
    end

    // Output register with a skid word behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_tready)
        begin
            if (res_push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_tready)
        begin
            if (res_push)
            begin
                skid_data_reg <= res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (res_push)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {5'b00000, out_data_reg.relay, out_data_reg.dot, out_data_reg.temp};
    assign m_tuser = out_data_reg.mode;

    // The ring is never written and read at the same slot in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && s_accept && s_tuser == OP_SAMPLE && p1_slot_reg == slot_reg))
        else $error("ring slot written and read in the same cycle");

    // Once the ring has filled, it stays warmed up.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(warmed_reg) |-> warmed_reg)
        else $error("warm-up flag fell");

    // The skid word is only ever held behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without an output word");

    // Before warm-up a tick always shows dashes with the relay off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !p4_warm_reg) |-> (res.mode == MODE_DASHES && !res.relay))
        else $error("tick before warm-up not shown as dashes");

endmodule
